### rtl/okvt_pkg.sv
// ----------------------------------------------------------------------------
// okvt_pkg: shared codes for the ordered key/value table
// Request kinds and result status codes.
// ----------------------------------------------------------------------------
package okvt_pkg;

  localparam int KIND_BITS   = 3;
  localparam int STATUS_BITS = 2;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_FIND      = 3'd0,
    KIND_PUT       = 3'd1,
    KIND_ERASE_KEY = 3'd2,
    KIND_ERASE_POS = 3'd3,
    KIND_READ_POS  = 3'd4
  } kind_t;

  typedef logic [STATUS_BITS-1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_MISS  = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_RANGE = 2'd3;

endpackage

### rtl/okvt_mem.sv
// ----------------------------------------------------------------------------
// okvt_mem: key/value entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module okvt_mem #(
  parameter int DEPTH      = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int ADDR_BITS  = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_BITS-1:0]  waddr,
  input  logic [KEY_BITS-1:0]   wkey,
  input  logic [VALUE_BITS-1:0] wval,
  input  logic [ADDR_BITS-1:0]  raddr,
  output logic [KEY_BITS-1:0]   rkey,
  output logic [VALUE_BITS-1:0] rval
);

  logic [KEY_BITS-1:0]   key_mem [DEPTH];
  logic [VALUE_BITS-1:0] val_mem [DEPTH];

  // write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      val_mem[waddr] <= wval;
    end
  end

  // register the read data
  always_ff @(posedge clk) begin
    rkey <= key_mem[raddr];
    rval <= val_mem[raddr];
  end

endmodule

### rtl/ordered_key_value_table.sv
// ----------------------------------------------------------------------------
// ordered_key_value_table: small associative table kept in insertion order
// A sequencer walks the entries one at a time through a single key comparator
// and a single-port-read entry memory; erase moves later entries down by one.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with kind, key_in, value_in and position_in; the item is taken
//   at a rising edge where start is high and busy is low. busy, when raised,
//   stays high until the result is out. The result appears on status, existed,
//   position_out, key_out, value_out and entry_count for one cycle with done
//   high; the receiver cannot stall it. entry_count also shows the live count.
// Work per item, with n = entries visited and m = entries moved by an erase:
//   find / put / erase by key: one memory read plus one compare per entry
//   visited (a miss visits all entries, or one entry when the table is
//   empty); erase then moves m entries down, one read and one write each,
//   plus one final read. Read and erase at position visit one entry.
//   Out-of-range positions and unused kinds finish in idle and never raise busy.
//   The next item may start in the cycle that done is high.
// Reset clears the entry count and the sequencer; entry contents are left
// as they are and are never read before being written.
// ----------------------------------------------------------------------------
module ordered_key_value_table
  import okvt_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [KIND_BITS-1:0]            kind,
  input  logic signed [KEY_BITS-1:0]      key_in,
  input  logic signed [VALUE_BITS-1:0]    value_in,
  input  logic [$clog2(DEPTH)-1:0]        position_in,
  output logic                            done,
  output logic [STATUS_BITS-1:0]          status,
  output logic                            existed,
  output logic [$clog2(DEPTH)-1:0]        position_out,
  output logic signed [KEY_BITS-1:0]      key_out,
  output logic signed [VALUE_BITS-1:0]    value_out,
  output logic [$clog2(DEPTH+1)-1:0]      entry_count
);

  localparam int PosW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_t;

  state_t                state;
  kind_t                 kind_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [PosW-1:0]       idx;
  logic [CntW-1:0]       count;

  logic                  we;
  logic [PosW-1:0]       waddr;
  logic [KEY_BITS-1:0]   wkey;
  logic [VALUE_BITS-1:0] wval;
  logic [PosW-1:0]       raddr;
  logic [KEY_BITS-1:0]   rkey;
  logic [VALUE_BITS-1:0] rval;

  logic                  by_pos;
  logic                  hit;
  logic                  more;
  logic                  full;
  logic                  is_put;

  okvt_mem #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS),
    .ADDR_BITS  (PosW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wkey  (wkey),
    .wval  (wval),
    .raddr (raddr),
    .rkey  (rkey),
    .rval  (rval)
  );

  // shared compare unit and loop bounds
  assign by_pos = (kind_r == KIND_ERASE_POS) || (kind_r == KIND_READ_POS);
  assign is_put = (kind_r == KIND_PUT);
  assign hit    = (CntW'(idx) < count) && (by_pos || (rkey == key_r));
  assign more   = (CntW'(idx) + CntW'(1)) < count;
  assign full   = (count == CntW'(DEPTH));

  assign busy        = (state != S_IDLE);
  assign entry_count = count;

  // read the scanned entry, or the one above it while moving entries down
  assign raddr = (state == S_SHIFT_RD) ? PosW'(idx + PosW'(1)) : idx;

  // drive the write port: overwrite, append, or move down
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wkey  = key_r;
    wval  = val_r;
    case (state)
      S_SCAN_CMP: begin
        if (hit && is_put) begin
          we = 1'b1;
        end else if (!hit && !more && is_put && !full) begin
          we    = 1'b1;
          waddr = count[PosW-1:0];
        end
      end
      S_SHIFT_WR: begin
        we   = 1'b1;
        wkey = rkey;
        wval = rval;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // sequencer, entry count and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            kind_r       <= kind_t'(kind);
            key_r        <= key_in;
            val_r        <= value_in;
            existed      <= 1'b0;
            position_out <= '0;
            key_out      <= '0;
            value_out    <= '0;
            case (kind_t'(kind))
              KIND_FIND, KIND_PUT, KIND_ERASE_KEY: begin
                idx   <= '0;
                state <= S_SCAN_RD;
              end
              KIND_ERASE_POS, KIND_READ_POS: begin
                if (CntW'(position_in) < count) begin
                  idx   <= position_in;
                  state <= S_SCAN_RD;
                end else begin
                  status <= ST_RANGE;
                  done   <= 1'b1;
                end
              end
              default: begin
                status <= ST_OK;
                done   <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (hit) begin
            status       <= ST_OK;
            existed      <= is_put;
            position_out <= idx;
            key_out      <= is_put ? key_r : rkey;
            value_out    <= is_put ? val_r : rval;
            if ((kind_r == KIND_ERASE_KEY) || (kind_r == KIND_ERASE_POS)) begin
              state <= S_SHIFT_RD;
            end else begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end else if (more) begin
            idx   <= PosW'(idx + PosW'(1));
            state <= S_SCAN_RD;
          end else begin
            // no match: append on put if room, else full; miss for other kinds
            if (is_put && !full) begin
              status       <= ST_OK;
              position_out <= count[PosW-1:0];
              key_out      <= key_r;
              value_out    <= val_r;
              count        <= count + CntW'(1);
            end else if (is_put) begin
              status <= ST_FULL;
            end else begin
              status <= ST_MISS;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SHIFT_RD: begin
          if (more) begin
            state <= S_SHIFT_WR;
          end else begin
            count <= count - CntW'(1);
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SHIFT_WR: begin
          idx   <= PosW'(idx + PosW'(1));
          state <= S_SHIFT_RD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("entry count beyond depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind == KIND_FIND || kind == KIND_PUT || kind == KIND_ERASE_KEY))
      |=> busy)
    else $error("key request did not start a scan");

  a_full_only_full: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (full && !existed))
    else $error("full status with room left");

  a_existed_ok: assert property (@(posedge clk) disable iff (rst)
    (done && existed) |-> (status == ST_OK))
    else $error("overwrite reported with error status");

  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> ($past(busy) || $past(start)))
    else $error("result without an item");

endmodule
